/* design/point_rotate_about_center_defines.svh */
// Assertion macros for the point rotation RTL.
// Included by the top level; needs nothing else.
`ifndef POINT_ROTATE_ABOUT_CENTER_DEFINES_SVH
`define POINT_ROTATE_ABOUT_CENTER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PRAC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, live during reset as well.
`define PRAC_ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/prac_pkg.sv */
// Package for the point rotation block: CORDIC constants, arctangent table
// and register index codes. Depends on nothing.
`default_nettype none

package prac_pkg;

   localparam int COORD_WIDTH_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int LUT_LEN           = 24;
   localparam int VEC_W             = 32;   // Q28 sine/cosine datapath
   localparam int ANG_W             = 32;   // binary angle, 2^32 per turn
   localparam int FRAC_Q            = 28;
   localparam int TURN_W            = 16;

   localparam logic signed [VEC_W-1:0] GAIN_Q28 = 32'sd163008219;

   localparam logic [ANG_W-1:0] ATAN_LUT [LUT_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [1:0] {
      CSR_CENTER_X   = 2'd0,
      CSR_CENTER_Y   = 2'd1,
      CSR_TURN_ANGLE = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

/* design/prac_cordic_cell.sv */
// One CORDIC micro-rotation cell with its pipeline register and a
// side-band payload that travels alongside. Depends on prac_pkg.
`default_nettype none

module prac_cordic_cell #(
   parameter int STAGE = 0,
   parameter int PAY_W = 50
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output      logic                                in_ready,
   input  wire logic signed [prac_pkg::VEC_W-1:0]   in_x,
   input  wire logic signed [prac_pkg::VEC_W-1:0]   in_y,
   input  wire logic signed [prac_pkg::ANG_W-1:0]   in_z,
   input  wire logic        [PAY_W-1:0]             in_pay,
   output      logic                                out_valid,
   input  wire logic                                out_ready,
   output      logic signed [prac_pkg::VEC_W-1:0]   out_x,
   output      logic signed [prac_pkg::VEC_W-1:0]   out_y,
   output      logic signed [prac_pkg::ANG_W-1:0]   out_z,
   output      logic        [PAY_W-1:0]             out_pay
);
   import prac_pkg::*;

   localparam logic signed [ANG_W-1:0] STEP_ANGLE = ATAN_LUT[STAGE];

   logic                     valid_ff;
   logic signed [VEC_W-1:0]  x_ff, x_in;
   logic signed [VEC_W-1:0]  y_ff, y_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic        [PAY_W-1:0]  pay_ff;
   logic signed [VEC_W-1:0]  x_shr, y_shr;

   assign in_ready = !valid_ff || out_ready;

   // Arithmetic shifts are floor divisions by 2^STAGE.
   always_comb begin
      x_shr = in_x >>> STAGE;
      y_shr = in_y >>> STAGE;
      if (!in_z[ANG_W-1]) begin
         x_in = in_x - y_shr;
         y_in = in_y + x_shr;
         z_in = in_z - STEP_ANGLE;
      end else begin
         x_in = in_x + y_shr;
         y_in = in_y - x_shr;
         z_in = in_z + STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_pay   = pay_ff;

endmodule

`default_nettype wire

/* design/prac_combine.sv */
// Output pipeline: products with sine and cosine, recentring sum with
// rounding bias, then floor shift and saturation. Depends on prac_pkg.
`default_nettype none

module prac_combine #(
   parameter int COORD_WIDTH = prac_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output      logic                                in_ready,
   input  wire logic signed [prac_pkg::VEC_W-1:0]   in_cos,
   input  wire logic signed [prac_pkg::VEC_W-1:0]   in_sin,
   input  wire logic signed [COORD_WIDTH:0]         in_dx,
   input  wire logic signed [COORD_WIDTH:0]         in_dy,
   input  wire logic signed [COORD_WIDTH-1:0]       center_x,
   input  wire logic signed [COORD_WIDTH-1:0]       center_y,
   output      logic                                out_valid,
   input  wire logic                                out_ready,
   output      logic signed [COORD_WIDTH-1:0]       out_rx,
   output      logic signed [COORD_WIDTH-1:0]       out_ry,
   output      logic                                out_clip
);
   import prac_pkg::*;

   localparam int PW = COORD_WIDTH + 1 + VEC_W;   // product width
   localparam int SW = PW + 2;                    // sum width
   localparam int RW = SW - FRAC_Q;               // rounded width

   localparam logic signed [SW-1:0] ROUND_BIAS =
      {{(SW-FRAC_Q){1'b0}}, 1'b1, {(FRAC_Q-1){1'b0}}};
   localparam logic signed [RW-1:0] HI_LIM =
      {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] LO_LIM =
      {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic                    m_valid_ff, s_valid_ff, o_valid_ff;
   logic                    m_ready, s_ready, o_ready;
   logic signed [PW-1:0]    xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [SW-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic signed [RW-1:0]    rx_full, ry_full;
   logic signed [COORD_WIDTH-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic                    clip_ff, clip_in;

   assign o_ready  = !o_valid_ff || out_ready;
   assign s_ready  = !s_valid_ff || o_ready;
   assign m_ready  = !m_valid_ff || s_ready;
   assign in_ready = m_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= in_valid;
         if (s_ready) s_valid_ff <= m_valid_ff;
         if (o_ready) o_valid_ff <= s_valid_ff;
      end
   end

   // Multiply stage: four exact products.
   always_ff @(posedge clock) begin
      if (m_ready && in_valid) begin
         xc_ff <= in_dx * in_cos;
         ys_ff <= in_dy * in_sin;
         xs_ff <= in_dx * in_sin;
         yc_ff <= in_dy * in_cos;
      end
   end

   // Sum stage. Change centre registers only with pipe empty; unchecked.
   always_comb begin
      ax_in = (SW'(center_x) <<< FRAC_Q) + SW'(xc_ff) + SW'(ys_ff) + ROUND_BIAS;
      ay_in = (SW'(center_y) <<< FRAC_Q) - SW'(xs_ff) + SW'(yc_ff) + ROUND_BIAS;
   end

   always_ff @(posedge clock) begin
      if (s_ready && m_valid_ff) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   // Round and saturate stage.
   always_comb begin
      rx_full = ax_ff[SW-1:FRAC_Q];
      ry_full = ay_ff[SW-1:FRAC_Q];
      clip_in = 1'b0;
      if (rx_full > HI_LIM) begin
         rx_in   = HI_LIM[COORD_WIDTH-1:0];
         clip_in = 1'b1;
      end else if (rx_full < LO_LIM) begin
         rx_in   = LO_LIM[COORD_WIDTH-1:0];
         clip_in = 1'b1;
      end else begin
         rx_in = rx_full[COORD_WIDTH-1:0];
      end
      if (ry_full > HI_LIM) begin
         ry_in   = HI_LIM[COORD_WIDTH-1:0];
         clip_in = 1'b1;
      end else if (ry_full < LO_LIM) begin
         ry_in   = LO_LIM[COORD_WIDTH-1:0];
         clip_in = 1'b1;
      end else begin
         ry_in = ry_full[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && s_valid_ff) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         clip_ff <= clip_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_rx    = rx_ff;
   assign out_ry    = ry_ff;
   assign out_clip  = clip_ff;

endmodule

`default_nettype wire

/* design/point_rotate_about_center.sv */
// Registers from a req transaction to its rsp transaction: entry register, one
// cell per stage (CORDIC_STAGES, at most 24), then the multiply, sum and
// round/saturate registers. Throughput: one point per cycle while rsp is ready.
// Every stage has its own valid bit, so bubbles are squeezed out while rsp stalls.
// Reset (synchronous, active high) empties the pipeline and clears the centre
// and angle registers to zero.
`default_nettype none
`include "point_rotate_about_center_defines.svh"

module point_rotate_about_center #(
   parameter int COORD_WIDTH   = prac_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = prac_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Input points.
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // point_x, point_y, then zero padding to whole bytes
   input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // Rotated points.
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // rotated_x, rotated_y, then zero padding to whole bytes
   output      logic [((2*COORD_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // clipped
   output      logic                                   rsp_tuser,
   // Register writes.
   input  wire logic                                   csr_we,
   input  wire logic [1:0]                             csr_index,
   input  wire logic [(COORD_WIDTH > prac_pkg::TURN_W ?
                       COORD_WIDTH : prac_pkg::TURN_W)-1:0] csr_wdata
);
   import prac_pkg::*;

   localparam int NSTAGE = (CORDIC_STAGES > LUT_LEN) ? LUT_LEN : CORDIC_STAGES;
   localparam int DW     = COORD_WIDTH + 1;       // centre-relative offset width
   localparam int PAY_W  = 2 * DW;
   localparam int BUS_W  = ((2*COORD_WIDTH+7)/8)*8;

   // Configuration registers. The host must write them only while no point is in
   // flight (not enforced); the datapath reads them directly where it needs them.
   logic signed [COORD_WIDTH-1:0] center_x_ff;
   logic signed [COORD_WIDTH-1:0] center_y_ff;
   logic        [TURN_W-1:0]      turn_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         turn_angle_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:   center_x_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_TURN_ANGLE: turn_angle_ff <= csr_wdata[TURN_W-1:0];
            default: ;      // unknown index: the write is dropped
         endcase
      end
   end

   // Links between the entry register (link 0) and the chain of cells.
   logic                    link_valid [NSTAGE+1];
   logic                    link_ready [NSTAGE+1];
   logic signed [VEC_W-1:0] link_x     [NSTAGE+1];
   logic signed [VEC_W-1:0] link_y     [NSTAGE+1];
   logic signed [ANG_W-1:0] link_z     [NSTAGE+1];
   logic        [PAY_W-1:0] link_pay   [NSTAGE+1];

   // Entry stage: take the offsets from the centre and fold the angle into
   // the right half plane. For angles in the second and third quadrants the
   // start vector is negated and half a turn is removed, which on a 32-bit
   // binary angle is simply an inversion of the top bit.
   logic signed [COORD_WIDTH-1:0] point_x, point_y;
   logic signed [DW-1:0]          dx_in, dy_in;
   logic        [ANG_W-1:0]       ang;
   logic                          fold;
   logic signed [VEC_W-1:0]       x0_in;
   logic signed [ANG_W-1:0]       z0_in;
   logic                          entry_valid_ff;
   logic signed [VEC_W-1:0]       entry_x_ff;
   logic signed [ANG_W-1:0]       entry_z_ff;
   logic        [PAY_W-1:0]       entry_pay_ff;

   assign point_x = req_tdata[COORD_WIDTH-1:0];
   assign point_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

   always_comb begin
      dx_in = DW'(point_x) - DW'(center_x_ff);
      dy_in = DW'(point_y) - DW'(center_y_ff);
      ang   = {turn_angle_ff, {(ANG_W-TURN_W){1'b0}}};
      fold  = ang[ANG_W-1] ^ ang[ANG_W-2];
      x0_in = fold ? -GAIN_Q28 : GAIN_Q28;
      z0_in = fold ? {~ang[ANG_W-1], ang[ANG_W-2:0]} : ang;
   end

   assign req_tready = !entry_valid_ff || link_ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (req_tready) begin
         entry_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         entry_x_ff   <= x0_in;
         entry_z_ff   <= z0_in;
         entry_pay_ff <= {dy_in, dx_in};
      end
   end

   assign link_valid[0] = entry_valid_ff;
   assign link_ready[0] = req_tready;
   assign link_x[0]     = entry_x_ff;
   assign link_y[0]     = '0;
   assign link_z[0]     = entry_z_ff;
   assign link_pay[0]   = entry_pay_ff;

   // Ready seen by each cell: the next cell's input ready, or the combiner's.
   logic tail_ready_chain [NSTAGE];
   logic comb_ready;

   // One micro-rotation per cell; the offsets ride along as payload.
   for (genvar k = 0; k < NSTAGE; k++) begin : g_cell
      prac_cordic_cell #(
         .STAGE (k),
         .PAY_W (PAY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k+1]),
         .in_x      (link_x[k]),
         .in_y      (link_y[k]),
         .in_z      (link_z[k]),
         .in_pay    (link_pay[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (tail_ready_chain[k]),
         .out_x     (link_x[k+1]),
         .out_y     (link_y[k+1]),
         .out_z     (link_z[k+1]),
         .out_pay   (link_pay[k+1])
      );
   end

   for (genvar k = 0; k < NSTAGE; k++) begin : g_ready
      if (k == NSTAGE-1) begin : g_last
         assign tail_ready_chain[k] = comb_ready;
      end else begin : g_mid
         assign tail_ready_chain[k] = link_ready[k+2];
      end
   end

   // After the last cell x holds the cosine and y the sine, in Q28.
   logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y;
   logic                          clipped;

   prac_combine #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NSTAGE]),
      .in_ready  (comb_ready),
      .in_cos    (link_x[NSTAGE]),
      .in_sin    (link_y[NSTAGE]),
      .in_dx     (link_pay[NSTAGE][DW-1:0]),
      .in_dy     (link_pay[NSTAGE][PAY_W-1:DW]),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rx    (rotated_x),
      .out_ry    (rotated_y),
      .out_clip  (clipped)
   );

   assign rsp_tdata = BUS_W'({rotated_y, rotated_x});
   assign rsp_tuser = clipped;

   // Bounds of the coordinate range, for checking clipped results.
   localparam logic [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic res_clipped;
   logic res_on_bound;

   assign res_clipped  = rsp_tvalid && rsp_tuser;
   assign res_on_bound = rotated_x == COORD_HI || rotated_x == COORD_LO ||
                         rotated_y == COORD_HI || rotated_y == COORD_LO;

   // A clipped result must sit on a bound of the coordinate range.
   `PRAC_ASSERT_IMP(a_clip_on_bound, clock, reset, res_clipped, res_on_bound, "clip off bound")
   // With the result side open, the ready chain must open all the way back.
   `PRAC_ASSERT_IMP(a_ready_chain, clock, reset, rsp_tready, req_tready, "input stalled")
   // An empty entry register always takes a transaction.
   `PRAC_ASSERT_IMP(a_entry_free, clock, reset, !entry_valid_ff, req_tready, "entry not ready")
   // Reset flushes every stage.
   `PRAC_ASSERT_NEXT_NR(a_reset_flush, clock, reset, !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire
